FILE: hw/rtl/bup_pkg.sv
// bup_pkg: shared constants, state codes and control structs for the
// bilinear upsampler; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bup_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int MAX_IN_W    = 256;
  localparam int MAX_IN_H    = 256;
  localparam int X_BITS      = $clog2(MAX_IN_W);
  localparam int Y_BITS      = $clog2(MAX_IN_H);
  localparam int ADDR_BITS   = X_BITS + Y_BITS;
  localparam int DST_BITS    = 12;
  localparam int INSZ_BITS   = 9;
  localparam int OUTSZ_BITS  = 13;
  localparam int PROD_BITS   = DST_BITS + 1 + INSZ_BITS;
  localparam int NUM_BITS    = PROD_BITS + FRAC_BITS;
  localparam int DEN_BITS    = OUTSZ_BITS + 1;
  localparam int QUO_BITS    = INSZ_BITS + FRAC_BITS;
  localparam int CNT_BITS    = $clog2(NUM_BITS + 1);
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 13;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IN_HEIGHT    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IN_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_HEIGHT   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CORNER_ALIGN = 3'd4;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_PREP, S_DIV,
    S_RD0, S_RD1, S_RD2, S_RD3, S_RD4,
    S_ROW, S_COL, S_FIN, S_OUT
  } bup_state_t;

  typedef struct packed {
    logic                start;
    logic [NUM_BITS-1:0] num;
    logic [DEN_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [QUO_BITS-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bup_if.sv
// bup_in_if / bup_out_if: valid-ready channels for the upsampler
// depends on bup_pkg
`timescale 1ns / 1ps
`default_nettype none
interface bup_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic        [bup_pkg::X_BITS-1:0]    src_x;
  logic        [bup_pkg::Y_BITS-1:0]    src_y;
  logic signed [bup_pkg::SAMPLE_BITS-1:0] sample;
  logic        [bup_pkg::DST_BITS-1:0]  dst_x;
  logic        [bup_pkg::DST_BITS-1:0]  dst_y;
  modport source(output valid, kind, src_x, src_y, sample, dst_x, dst_y, input ready);
  modport sink(input valid, kind, src_x, src_y, sample, dst_x, dst_y, output ready);
endinterface

interface bup_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [bup_pkg::SAMPLE_BITS-1:0] pixel_value;
  logic                                   range_error;
  modport source(output valid, pixel_value, range_error, input ready);
  modport sink(input valid, pixel_value, range_error, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/bilinear_upsample_2d.sv
// bilinear_upsample_2d: top level, query sequencer and blend datapath
// depends on bup_pkg, bup_if, bup_div, bup_plane
//
//   channel  dir  payload
//   in_ch    in   kind, src_x, src_y, sample, dst_x, dst_y
//   out_ch   out  pixel_value, range_error (one beat per query)
//   cfg_*    in   write enable, register index, data
//
// a sample write is taken in the idle state; the plane is written on the accept edge
// an in-range query runs the serial divider once per axis, unless that coordinate is
// zero, then makes four reads of the single-port plane
// an out-of-range query goes from idle straight to the output state
// reset clears control and config only; plane entries are undefined until written
// a finished result waits in the output register; a new item is taken meanwhile
`timescale 1ns / 1ps
`default_nettype none
module bilinear_upsample_2d (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  bup_in_if.sink                               in_ch,
  bup_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [bup_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [bup_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import bup_pkg::*;

  // configuration
  logic [INSZ_BITS-1:0]  in_h_r, in_w_r;
  logic [OUTSZ_BITS-1:0] out_h_r, out_w_r;
  logic                  align_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_h_r  <= INSZ_BITS'(1);
      in_w_r  <= INSZ_BITS'(1);
      out_h_r <= OUTSZ_BITS'(1);
      out_w_r <= OUTSZ_BITS'(1);
      align_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IN_HEIGHT:    in_h_r  <= cfg_data[INSZ_BITS-1:0];
        CFG_IN_WIDTH:     in_w_r  <= cfg_data[INSZ_BITS-1:0];
        CFG_OUT_HEIGHT:   out_h_r <= cfg_data[OUTSZ_BITS-1:0];
        CFG_OUT_WIDTH:    out_w_r <= cfg_data[OUTSZ_BITS-1:0];
        CFG_CORNER_ALIGN: align_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective input sizes: zero acts as one, clamp at the plane size
  logic [INSZ_BITS-1:0] in_w_eff, in_h_eff;
  always_comb begin
    in_w_eff = in_w_r;
    if (in_w_r == '0) in_w_eff = INSZ_BITS'(1);
    else if (in_w_r > INSZ_BITS'(MAX_IN_W)) in_w_eff = INSZ_BITS'(MAX_IN_W);
    in_h_eff = in_h_r;
    if (in_h_r == '0) in_h_eff = INSZ_BITS'(1);
    else if (in_h_r > INSZ_BITS'(MAX_IN_H)) in_h_eff = INSZ_BITS'(MAX_IN_H);
  end

  bup_state_t state_r, state_nxt;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  logic                 axis_r;          // 0 = column, 1 = row
  logic [DST_BITS-1:0]  dx_r, dy_r;
  logic [PROD_BITS-1:0] prod_r;
  logic [X_BITS-1:0]    px_r;
  logic [Y_BITS-1:0]    py_r;
  logic [FRAC_BITS-1:0] fx_r, fy_r;
  logic                 sx_r, sy_r;
  logic signed [SAMPLE_BITS-1:0] sa_r, sb_r, sc_r, sd_r;
  logic signed [2*SAMPLE_BITS:0] top_r, bot_r;
  logic signed [2*SAMPLE_BITS+FRAC_BITS+3:0] tot_r;
  logic signed [SAMPLE_BITS-1:0] res_r;
  logic                 err_r;
  logic                 out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_pix_r;
  logic                 out_err_r;

  logic accept, q_range_bad, out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_range_bad = ({1'b0, in_ch.dst_x} >= out_w_r) || ({1'b0, in_ch.dst_y} >= out_h_r);
  assign out_free    = !out_valid_r || out_ch.ready;

  // per-axis operands
  logic [DST_BITS-1:0]   dst_a;
  logic [INSZ_BITS-1:0]  in_a;
  logic [OUTSZ_BITS-1:0] out_a;
  assign dst_a = axis_r ? dy_r : dx_r;
  assign in_a  = axis_r ? in_h_eff : in_w_eff;
  assign out_a = axis_r ? out_h_r : out_w_r;

  // align: dst*(in-1); half-pixel: (2*dst+1)*in
  logic [DST_BITS:0]    mul_a;
  logic [INSZ_BITS-1:0] mul_b;
  assign mul_a = align_r ? {1'b0, dst_a} : {dst_a, 1'b1};
  assign mul_b = align_r ? in_a - 1'b1 : in_a;

  // coordinate preparation and the zero-coordinate cases
  logic coord_zero;
  logic [NUM_BITS-1:0] prep_num;
  logic [DEN_BITS-1:0] prep_den;
  always_comb begin
    if (align_r) begin
      coord_zero = (out_a <= OUTSZ_BITS'(1));
      prep_num   = {prod_r, FRAC_BITS'(0)};
      prep_den   = DEN_BITS'(out_a - 1'b1);
    end else begin
      coord_zero = (prod_r <= PROD_BITS'(out_a));
      prep_num   = {PROD_BITS'(prod_r - PROD_BITS'(out_a)), FRAC_BITS'(0)};
      prep_den   = {out_a, 1'b0};
    end
  end

  // split the coordinate into base position, weight and edge step
  logic [QUO_BITS-1:0]  coord;
  logic [INSZ_BITS-1:0] pos_raw, in_last;
  logic [INSZ_BITS-1:0] pos_c;
  logic [FRAC_BITS-1:0] frac_c;
  logic                 step_c;
  always_comb begin
    coord   = (state_r == S_PREP) ? '0 : div_rsp.quo;
    pos_raw = coord[QUO_BITS-1:FRAC_BITS];
    in_last = in_a - 1'b1;
    pos_c   = pos_raw;
    frac_c  = coord[FRAC_BITS-1:0];
    if (pos_raw > in_last) begin
      pos_c  = in_last;
      frac_c = '0;
    end
    step_c = (pos_c < in_last);
  end

  logic coord_store;
  assign coord_store = ((state_r == S_PREP) && coord_zero) ||
                       ((state_r == S_DIV) && div_rsp.done);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept && in_ch.kind == KIND_QUERY) begin
        state_nxt = q_range_bad ? S_OUT : S_MUL;
      end
      S_MUL:  state_nxt = S_PREP;
      S_PREP: state_nxt = coord_zero ? (axis_r ? S_RD0 : S_MUL) : S_DIV;
      S_DIV:  if (div_rsp.done) state_nxt = axis_r ? S_RD0 : S_MUL;
      S_RD0:  state_nxt = S_RD1;
      S_RD1:  state_nxt = S_RD2;
      S_RD2:  state_nxt = S_RD3;
      S_RD3:  state_nxt = S_RD4;
      S_RD4:  state_nxt = S_ROW;
      S_ROW:  state_nxt = S_COL;
      S_COL:  state_nxt = S_FIN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer: plane port, divider start and input ready
  logic                   plane_we;
  logic [ADDR_BITS-1:0]   plane_addr;
  logic signed [SAMPLE_BITS-1:0] plane_rd;
  logic [X_BITS-1:0]      px1;
  logic [Y_BITS-1:0]      py1;
  assign px1 = px_r + X_BITS'(sx_r);
  assign py1 = py_r + Y_BITS'(sy_r);

  always_comb begin
    plane_we      = 1'b0;
    plane_addr    = {in_ch.src_y, in_ch.src_x};
    div_req.start = 1'b0;
    div_req.num   = prep_num;
    div_req.den   = prep_den;
    in_ch.ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        plane_we    = in_ch.valid && in_ch.kind == KIND_WRITE;
      end
      S_PREP: div_req.start = !coord_zero;
      S_RD0:  plane_addr = {py_r, px_r};
      S_RD1:  plane_addr = {py_r, px1};
      S_RD2:  plane_addr = {py1, px_r};
      S_RD3:  plane_addr = {py1, px1};
      default: ;
    endcase
  end

  bup_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  bup_plane u_plane (
    .clk   (clk),
    .we    (plane_we),
    .addr  (plane_addr),
    .wdata (in_ch.sample),
    .rdata (plane_rd)
  );

  // blend arithmetic: a*(1-f)+b*f written as a*one + (b-a)*f
  logic signed [SAMPLE_BITS:0]   dif_top, dif_bot;
  logic signed [FRAC_BITS:0]     fx_s, fy_s;
  logic signed [2*SAMPLE_BITS:0] top_c, bot_c;
  logic signed [2*SAMPLE_BITS+1:0] dif_col;
  logic signed [2*SAMPLE_BITS+FRAC_BITS+3:0] tot_c;
  logic signed [2*SAMPLE_BITS+FRAC_BITS+3:0] rnd;
  logic signed [SAMPLE_BITS+3:0] rnd_int;
  localparam logic signed [SAMPLE_BITS+3:0] SMAX = (SAMPLE_BITS+4)'((1 << (SAMPLE_BITS-1)) - 1);
  localparam logic signed [SAMPLE_BITS+3:0] SMIN = -(SAMPLE_BITS+4)'(1 << (SAMPLE_BITS-1));

  always_comb begin
    fx_s    = {1'b0, fx_r};
    fy_s    = {1'b0, fy_r};
    dif_top = (SAMPLE_BITS+1)'(sb_r) - (SAMPLE_BITS+1)'(sa_r);
    dif_bot = (SAMPLE_BITS+1)'(sd_r) - (SAMPLE_BITS+1)'(sc_r);
    top_c   = ((2*SAMPLE_BITS+1)'(sa_r) <<< FRAC_BITS) + (2*SAMPLE_BITS+1)'(dif_top * fx_s);
    bot_c   = ((2*SAMPLE_BITS+1)'(sc_r) <<< FRAC_BITS) + (2*SAMPLE_BITS+1)'(dif_bot * fx_s);
    dif_col = (2*SAMPLE_BITS+2)'(bot_r) - (2*SAMPLE_BITS+2)'(top_r);
    tot_c   = ((2*SAMPLE_BITS+FRAC_BITS+4)'(top_r) <<< FRAC_BITS) +
              (2*SAMPLE_BITS+FRAC_BITS+4)'(dif_col * fy_s);
    // round half up then floor shift
    rnd     = tot_r + ((2*SAMPLE_BITS+FRAC_BITS+4)'(1) <<< (2*FRAC_BITS-1));
    rnd_int = (SAMPLE_BITS+4)'(rnd >>> (2*FRAC_BITS));
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept) begin
      dx_r   <= in_ch.dst_x;
      dy_r   <= in_ch.dst_y;
      axis_r <= 1'b0;
      err_r  <= q_range_bad;
      res_r  <= '0;
    end
    if (state_r == S_MUL) prod_r <= PROD_BITS'(mul_a * mul_b);
    if (coord_store) begin
      axis_r <= 1'b1;
      if (axis_r) begin
        py_r <= pos_c[Y_BITS-1:0];
        fy_r <= frac_c;
        sy_r <= step_c;
      end else begin
        px_r <= pos_c[X_BITS-1:0];
        fx_r <= frac_c;
        sx_r <= step_c;
      end
    end
    if (state_r == S_RD1) sa_r <= plane_rd;
    if (state_r == S_RD2) sb_r <= plane_rd;
    if (state_r == S_RD3) sc_r <= plane_rd;
    if (state_r == S_RD4) sd_r <= plane_rd;
    if (state_r == S_ROW) begin
      top_r <= top_c;
      bot_r <= bot_c;
    end
    if (state_r == S_COL) tot_r <= tot_c;
    if (state_r == S_FIN) begin
      if (rnd_int > SMAX)      res_r <= SMAX[SAMPLE_BITS-1:0];
      else if (rnd_int < SMIN) res_r <= SMIN[SAMPLE_BITS-1:0];
      else                     res_r <= rnd_int[SAMPLE_BITS-1:0];
    end
    if (state_r == S_OUT && out_free) begin
      out_pix_r <= err_r ? '0 : res_r;
      out_err_r <= err_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)            out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_value = out_pix_r;
  assign out_ch.range_error = out_err_r;

  // an out-of-range query goes straight to the result with the flag set
  a_range_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && accept && in_ch.kind == KIND_QUERY && q_range_bad)
      |=> (state_r == S_OUT && err_r))
    else $error("out-of-range query not flagged");

  // divider results arrive only while the sequencer waits for them
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider done outside wait state");

  // base positions lie inside the plane before the reads start
  a_pos_in: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD0) |-> (({1'b0, px_r} < in_w_eff) && ({1'b0, py_r} < in_h_eff)))
    else $error("neighbor position beyond plane");

  // the plane is written only by a write beat
  a_plane_we: assert property (@(posedge clk) disable iff (!rst_n)
    plane_we |-> (accept && in_ch.kind == KIND_WRITE))
    else $error("plane written outside write beat");

endmodule
`default_nettype wire

FILE: hw/rtl/bup_div.sv
// bup_div: restoring divider, one quotient bit per cycle
// depends on bup_pkg
`timescale 1ns / 1ps
`default_nettype none
module bup_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bup_pkg::div_req_t req,
  output bup_pkg::div_rsp_t      rsp
);
  import bup_pkg::*;

  logic [NUM_BITS-1:0] num_r, num_nxt;
  logic [NUM_BITS-1:0] quo_r, quo_nxt;
  logic [DEN_BITS-1:0] den_r, den_nxt;
  logic [DEN_BITS-1:0] rem_r, rem_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [DEN_BITS:0]   rem_s;

  always_comb begin
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_s    = {rem_r, num_r[NUM_BITS-1]};
    if (req.start) begin
      num_nxt  = req.num;
      den_nxt  = req.den;
      rem_nxt  = '0;
      quo_nxt  = '0;
      cnt_nxt  = CNT_BITS'(NUM_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[NUM_BITS-2:0], 1'b0};
      if (rem_s >= {1'b0, den_r}) begin
        rem_nxt = DEN_BITS'(rem_s - {1'b0, den_r});
        quo_nxt = {quo_r[NUM_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = rem_s[DEN_BITS-1:0];
        quo_nxt = {quo_r[NUM_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r[QUO_BITS-1:0];

endmodule
`default_nettype wire

FILE: hw/rtl/bup_plane.sv
// bup_plane: single-port sample memory with registered read
// depends on bup_pkg
`timescale 1ns / 1ps
`default_nettype none
module bup_plane (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [bup_pkg::ADDR_BITS-1:0]      addr,
  input  wire logic signed [bup_pkg::SAMPLE_BITS-1:0] wdata,
  output logic signed [bup_pkg::SAMPLE_BITS-1:0]  rdata
);
  import bup_pkg::*;

  logic signed [SAMPLE_BITS-1:0] mem [MAX_IN_W*MAX_IN_H];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

FILE: verif/bilinear_upsample_2d_test.sv
// bilinear_upsample_2d_test: self-checking bench for the bilinear upsampler
// depends on bup_pkg, bup_if and bilinear_upsample_2d
`timescale 1ns / 1ps
module bilinear_upsample_2d_test;
  import bup_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 150;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] pixel_value;
    logic                          range_error;
  } pixel_t;

  // scoreboard: own copy of plane and registers, queue of predicted pixels
  class upsample_board;
    logic signed [SAMPLE_BITS-1:0] plane [MAX_IN_W*MAX_IN_H];
    int unsigned rows_in, cols_in, rows_out, cols_out;
    bit          align;
    pixel_t      pending_pixels[$];
    int          errors;

    function new();
      rows_in = 1; cols_in = 1; rows_out = 1; cols_out = 1; align = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned val);
      case (idx)
        CFG_IN_HEIGHT:    rows_in  = val & 'h1FF;
        CFG_IN_WIDTH:     cols_in  = val & 'h1FF;
        CFG_OUT_HEIGHT:   rows_out = val & 'h1FFF;
        CFG_OUT_WIDTH:    cols_out = val & 'h1FFF;
        CFG_CORNER_ALIGN: align    = val & 1;
        default: ;
      endcase
    endfunction

    function int unsigned clamp_in(int unsigned r, int unsigned mx);
      if (r == 0) return 1;
      return (r > mx) ? mx : r;
    endfunction

    // source coordinate in q16
    function longint map_coord(longint dst, longint isz, longint osz);
      longint num;
      if (osz == 0) osz = 1;
      if (align) begin
        if (osz <= 1) return 0;
        return ((dst * (isz - 1)) <<< FRAC_BITS) / (osz - 1);
      end
      num = (2 * dst + 1) * isz;
      if (num <= osz) return 0;
      return ((num - osz) <<< FRAC_BITS) / (2 * osz);
    endfunction

    function longint sample_at(longint x, longint y);
      return longint'(plane[y * MAX_IN_W + x]);
    endfunction

    function void note_input(logic kind, logic [X_BITS-1:0] sx, logic [Y_BITS-1:0] sy,
                             logic signed [SAMPLE_BITS-1:0] smp,
                             logic [DST_BITS-1:0] dx, logic [DST_BITS-1:0] dy);
      pixel_t p;
      longint cx, cy, px, py, fx, fy, one, top, bot, tot;
      int unsigned iw, ih, stx, sty;
      if (kind == KIND_WRITE) begin
        plane[{sy, sx}] = smp;
        return;
      end
      if (dx >= cols_out || dy >= rows_out) begin
        p.pixel_value = '0;
        p.range_error = 1'b1;
        pending_pixels.push_back(p);
        return;
      end
      one = longint'(1) <<< FRAC_BITS;
      iw = clamp_in(cols_in, MAX_IN_W);
      ih = clamp_in(rows_in, MAX_IN_H);
      cx = map_coord(dx, iw, cols_out);
      cy = map_coord(dy, ih, rows_out);
      px = cx >>> FRAC_BITS;  fx = cx & (one - 1);
      py = cy >>> FRAC_BITS;  fy = cy & (one - 1);
      if (px > iw - 1) begin px = iw - 1; fx = 0; end
      if (py > ih - 1) begin py = ih - 1; fy = 0; end
      stx = (px < iw - 1) ? 1 : 0;
      sty = (py < ih - 1) ? 1 : 0;
      top = sample_at(px, py) * (one - fx) + sample_at(px + stx, py) * fx;
      bot = sample_at(px, py + sty) * (one - fx) + sample_at(px + stx, py + sty) * fx;
      // round half up, arithmetic shift floors
      tot = (top * (one - fy) + bot * fy + (longint'(1) <<< (2*FRAC_BITS-1)))
            >>> (2 * FRAC_BITS);
      if (tot < -32768) tot = -32768;
      if (tot > 32767) tot = 32767;
      p.pixel_value = tot[SAMPLE_BITS-1:0];
      p.range_error = 1'b0;
      pending_pixels.push_back(p);
    endfunction

    function void check_pixel(logic signed [SAMPLE_BITS-1:0] pv, logic re);
      pixel_t e;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: pixel %0d err %0b", pv, re);
        return;
      end
      e = pending_pixels.pop_front();
      if (pv !== e.pixel_value || re !== e.range_error) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected pixel %0d err %0b, got pixel %0d err %0b",
                   e.pixel_value, e.range_error, pv, re);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  bup_in_if  in_ch();
  bup_out_if out_ch();

  bilinear_upsample_2d u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  upsample_board board = new();

  // sender burst state
  int burst_left = 0;
  // long receiver hold-off, requested once by the stimulus
  bit hold_go = 0;
  bit hold_used = 0;
  int hold_cnt = 0;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // drive known values before the first edge
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_WRITE;
    in_ch.src_x = '0;
    in_ch.src_y = '0;
    in_ch.sample = '0;
    in_ch.dst_x = '0;
    in_ch.dst_y = '0;
    out_ch.ready = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stall pattern from four modes, plus one long hold-off
  int rx_mode = 0;
  int rx_tick = 0;
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 64 == 0) rx_mode <= $urandom_range(0, 3);
    if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        2: out_ch.ready <= (rx_tick % 7) >= 3;
        default: out_ch.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // result beats are compared at the accept edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_pixel(out_ch.pixel_value, out_ch.range_error);
  end

  task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_BITS-1:0];
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one input beat, with random bursts and gaps in front
  task automatic send_beat(logic kind, int unsigned sx, int unsigned sy, int smp,
                           int unsigned dx, int unsigned dy);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.src_x <= sx[X_BITS-1:0];
    in_ch.src_y <= sy[Y_BITS-1:0];
    in_ch.sample <= smp[SAMPLE_BITS-1:0];
    in_ch.dst_x <= dx[DST_BITS-1:0];
    in_ch.dst_y <= dy[DST_BITS-1:0];
    do @(posedge clk); while (!in_ch.ready);
    board.note_input(kind, sx[X_BITS-1:0], sy[Y_BITS-1:0], smp[SAMPLE_BITS-1:0],
                     dx[DST_BITS-1:0], dy[DST_BITS-1:0]);
  endtask

  task automatic idle_in();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // wait for every predicted pixel, then let any query in flight finish
  task automatic drain();
    idle_in();
    while (board.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic setup(int unsigned ih, int unsigned iw, int unsigned oh, int unsigned ow,
                       int unsigned al);
    cfg_write(CFG_IN_HEIGHT, ih);
    cfg_write(CFG_IN_WIDTH, iw);
    cfg_write(CFG_OUT_HEIGHT, oh);
    cfg_write(CFG_OUT_WIDTH, ow);
    cfg_write(CFG_CORNER_ALIGN, al);
  endtask

  // fill the whole effective plane so that no query reads an unwritten entry
  task automatic fill_plane();
    int unsigned h, w;
    int smp;
    h = board.clamp_in(board.rows_in, MAX_IN_H);
    w = board.clamp_in(board.cols_in, MAX_IN_W);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        case ($urandom_range(0, 7))
          0: smp = -32768;
          1: smp = 32767;
          default: smp = $urandom_range(0, 65535) - 32768;
        endcase
        send_beat(KIND_WRITE, x, y, smp, $urandom_range(0, 4095), $urandom_range(0, 4095));
      end
  endtask

  task automatic query(int unsigned dx, int unsigned dy);
    send_beat(KIND_QUERY, $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 65535) - 32768, dx, dy);
  endtask

  // random mix inside the current setting: mostly in-range queries
  task automatic random_traffic(int n);
    int unsigned h, w;
    h = board.clamp_in(board.rows_in, MAX_IN_H);
    w = board.clamp_in(board.cols_in, MAX_IN_W);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0, 1: query($urandom_range(0, 4095), $urandom_range(0, 4095));
        2: send_beat(KIND_WRITE, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                     $urandom_range(0, 65535) - 32768, 0, 0);
        default: query((board.cols_out == 0) ? 0 : $urandom_range(0, board.cols_out - 1),
                       (board.rows_out == 0) ? 0 : $urandom_range(0, board.rows_out - 1));
      endcase
    end
  endtask

  initial begin
    int unsigned ih, iw, oh, ow;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // 2x2 plane to 4x4, align-corners, corners and range edges
    setup(2, 2, 4, 4, 1);
    fill_plane();
    query(0, 0);
    query(3, 3);
    query(1, 2);
    query(4, 0);
    query(0, 4);
    query(4095, 4095);
    drain();

    // zero input size and output size of one with align-corners
    setup(0, 0, 1, 1, 1);
    fill_plane();
    query(0, 0);
    query(1, 0);
    drain();

    // output size zero flags everything
    setup(3, 5, 0, 7, 0);
    query(0, 0);
    query(2, 1);
    drain();

    // widest plane, output width 4096, half-pixel
    setup(1, 256, 3, 4096, 0);
    fill_plane();
    query(4095, 2);
    query(0, 0);
    query(2048, 1);
    drain();

    // oversized height register acts as the maximum
    setup(511, 1, 4096, 2, 1);
    fill_plane();
    query(1, 4095);
    query(0, 0);
    query(1, 1234);
    drain();

    // random settings, mostly small; the long receiver hold-off in the first one
    for (int ph = 0; ph < 4; ph++) begin
      ih = $urandom_range(1, 8);
      iw = $urandom_range(1, 8);
      oh = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 40);
      ow = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 40);
      setup(ih, iw, oh, ow, $urandom_range(0, 1));
      fill_plane();
      if (ph == 0) hold_go = 1'b1;
      random_traffic(12);
      drain();
    end

    if (board.errors == 0 && board.pending_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

FILE: sim.f
hw/rtl/bup_pkg.sv
hw/rtl/bup_if.sv
hw/rtl/bup_div.sv
hw/rtl/bup_plane.sv
hw/rtl/bilinear_upsample_2d.sv
verif/bilinear_upsample_2d_test.sv
